### rtl/pldz_pkg.sv
package pldz_pkg;

  localparam int HIST_DEPTH = 2048;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int DIST_W     = 11;
  localparam int REC_W      = 12;
  localparam int LIMIT_W    = 26;
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  localparam logic [REC_W-1:0]   REC_MAX     = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20971520);

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_LIT_OVERRUN = 3'd1;
  localparam logic [2:0] ST_TRUNC_PAIR  = 3'd2;
  localparam logic [2:0] ST_BAD_DIST    = 3'd3;
  localparam logic [2:0] ST_OUT_LIMIT   = 3'd4;

  // Command byte ranges
  localparam logic [7:0] RUN_MAX    = 8'h08;
  localparam logic [7:0] PLAIN_MAX  = 8'h7F;
  localparam logic [7:0] SPACE_LEAD = 8'hC0;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] CASE_FLIP  = 8'h80;
  localparam logic [3:0] COPY_BIAS  = 4'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [HIST_AW-1:0] raddr;
  } hist_req_t;

endpackage

### rtl/pldz_hist_ram.sv
module pldz_hist_ram #(
  parameter int Depth = 2048,
  parameter int Width = 8,
  localparam int Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Write-first: a read of the entry being written returns the new byte
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pldz_out_fifo.sv
module pldz_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pldz_pkg::push_t                push_i,
  output logic [pldz_pkg::OFIFO_CW-1:0]  count_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,  // out_byte[7:0]
  output logic [2:0]                     m_axis_tuser_o,  // status[2:0]
  output logic                           m_axis_tlast_o
);
  import pldz_pkg::*;

  res_t                mem_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OFIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OFIFO_CW-1:0] count_q, count_d;
  logic                pop;
  res_t                head;

  assign pop  = m_axis_tvalid_o && m_axis_tready_i;
  assign head = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + OFIFO_AW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + OFIFO_AW'(1);
    end
    case ({push_i.valid, pop})
      2'b10:   count_d = count_q + OFIFO_CW'(1);
      2'b01:   count_d = count_q - OFIFO_CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.res;
    end
  end

  assign count_o         = count_q;
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = head.out_byte;
  assign m_axis_tuser_o  = head.status;
  assign m_axis_tlast_o  = head.run_last;

endmodule

### rtl/pldz_decoder.sv
module pldz_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [pldz_pkg::LIMIT_W-1:0]      cfg_wr_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        in_byte_i,
  input  logic                              record_last_i,
  input  logic [pldz_pkg::OFIFO_CW-1:0]     fifo_count_i,
  output pldz_pkg::push_t                   push_o,
  output pldz_pkg::hist_req_t               hist_req_o,
  input  logic [7:0]                        hist_rdata_i
);
  import pldz_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_COPY   = 2'd1;
  localparam logic [1:0] S_SPACE2 = 2'd2;
  localparam logic [1:0] S_ERR1   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [REC_W-1:0]   rec_q, rec_d;
  logic [LIMIT_W-1:0] total_q, total_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [3:0]         lit_q, lit_d;
  logic               pend_q, pend_d;
  logic [7:0]         phigh_q, phigh_d;
  logic [2:0]         err_q, err_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [HIST_AW-1:0] src_q, src_d;
  logic               last_q, last_d;
  logic [7:0]         sbyte_q, sbyte_d;
  logic               s2_vld_q, s2_vld_d;
  logic               s2_err_q, s2_err_d;
  logic               s2_last_q, s2_last_d;
  logic [HIST_AW-1:0] s2_waddr_q, s2_waddr_d;

  logic               lim_hit;
  logic               room;
  logic               accept;
  logic [REC_W-1:0]   rec_inc;
  logic [DIST_W-1:0]  pair_dist;
  logic [3:0]         lit_new;
  logic [OFIFO_CW:0]  fill_ahead;

  assign lim_hit    = (total_q >= limit_q);
  assign rec_inc    = (rec_q == REC_MAX) ? rec_q : rec_q + REC_W'(1);
  assign room       = (fifo_count_i < OFIFO_CW'(OFIFO_DEPTH));
  assign fill_ahead = {1'b0, fifo_count_i} + {{OFIFO_CW{1'b0}}, s2_vld_q};
  assign in_ready_o = (state_q == S_IDLE) && room && !s2_vld_q;
  assign accept     = in_valid_i && in_ready_o;
  assign pair_dist  = {phigh_q[5:0], in_byte_i[7:3]};
  assign lit_new    = lit_q - 4'd1;

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    rec_d      = rec_q;
    total_d    = total_q;
    lit_d      = lit_q;
    pend_d     = pend_q;
    phigh_d    = phigh_q;
    err_d      = err_q;
    cnt_d      = cnt_q;
    src_d      = src_q;
    last_d     = last_q;
    sbyte_d    = sbyte_q;
    s2_vld_d   = 1'b0;
    s2_err_d   = s2_err_q;
    s2_last_d  = s2_last_q;
    s2_waddr_d = s2_waddr_q;
    push_o     = '0;
    hist_req_o = '0;
    hist_req_o.waddr = wp_q;
    hist_req_o.raddr = src_q;

    // Copy stage two: write the fetched byte back and emit it, or emit the output-limit error
    if (s2_vld_q) begin
      push_o.valid = 1'b1;
      if (s2_err_q) begin
        push_o.res = '{out_byte: 8'h00, status: ST_OUT_LIMIT, run_last: 1'b1};
      end else begin
        hist_req_o.we    = 1'b1;
        hist_req_o.waddr = s2_waddr_q;
        hist_req_o.wdata = hist_rdata_i;
        push_o.res = '{out_byte: hist_rdata_i, status: ST_OK, run_last: s2_last_q};
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = record_last_i;
          if (err_q != ST_OK) begin
            push_o.valid = 1'b1;
            push_o.res   = '{out_byte: 8'h00, status: err_q, run_last: 1'b1};
          end else if (pend_q) begin
            pend_d = 1'b0;
            if ((pair_dist == '0) || ({1'b0, pair_dist} > rec_q)) begin
              err_d        = ST_BAD_DIST;
              push_o.valid = 1'b1;
              push_o.res   = '{out_byte: 8'h00, status: ST_BAD_DIST, run_last: 1'b1};
            end else begin
              cnt_d   = {1'b0, in_byte_i[2:0]} + COPY_BIAS;
              src_d   = wp_q - HIST_AW'(pair_dist);
              state_d = S_COPY;
            end
          end else if (lit_q != '0) begin
            lit_d        = lit_new;
            push_o.valid = 1'b1;
            if (lim_hit) begin
              err_d      = ST_OUT_LIMIT;
              push_o.res = '{out_byte: 8'h00, status: ST_OUT_LIMIT, run_last: 1'b1};
            end else begin
              hist_req_o.we    = 1'b1;
              hist_req_o.wdata = in_byte_i;
              wp_d    = wp_q + HIST_AW'(1);
              rec_d   = rec_inc;
              total_d = total_q + LIMIT_W'(1);
              push_o.res = '{out_byte: in_byte_i, status: ST_OK,
                             run_last: !(record_last_i && (lit_new != '0))};
              // Record closes with literals still owed
              if (record_last_i && (lit_new != '0)) begin
                err_d   = ST_LIT_OVERRUN;
                state_d = S_ERR1;
              end
            end
          end else if ((in_byte_i != 8'h00) && (in_byte_i <= RUN_MAX)) begin
            lit_d = in_byte_i[3:0];
            if (record_last_i) begin
              err_d        = ST_LIT_OVERRUN;
              push_o.valid = 1'b1;
              push_o.res   = '{out_byte: 8'h00, status: ST_LIT_OVERRUN, run_last: 1'b1};
            end
          end else if ((in_byte_i <= PLAIN_MAX) || (in_byte_i >= SPACE_LEAD)) begin
            push_o.valid = 1'b1;
            if (lim_hit) begin
              err_d      = ST_OUT_LIMIT;
              push_o.res = '{out_byte: 8'h00, status: ST_OUT_LIMIT, run_last: 1'b1};
            end else begin
              hist_req_o.we = 1'b1;
              wp_d    = wp_q + HIST_AW'(1);
              rec_d   = rec_inc;
              total_d = total_q + LIMIT_W'(1);
              if (in_byte_i <= PLAIN_MAX) begin
                hist_req_o.wdata = in_byte_i;
                push_o.res = '{out_byte: in_byte_i, status: ST_OK, run_last: 1'b1};
              end else begin
                hist_req_o.wdata = SPACE_CHAR;
                push_o.res = '{out_byte: SPACE_CHAR, status: ST_OK, run_last: 1'b0};
                sbyte_d = in_byte_i ^ CASE_FLIP;
                state_d = S_SPACE2;
              end
            end
          end else begin
            phigh_d = in_byte_i;
            pend_d  = 1'b1;
            if (record_last_i) begin
              err_d        = ST_TRUNC_PAIR;
              push_o.valid = 1'b1;
              push_o.res   = '{out_byte: 8'h00, status: ST_TRUNC_PAIR, run_last: 1'b1};
            end
          end
          if ((state_d == S_IDLE) && record_last_i && (err_d == ST_OK)) begin
            rec_d  = '0;
            lit_d  = '0;
            pend_d = 1'b0;
          end
        end
      end

      S_SPACE2: begin
        if (room) begin
          push_o.valid = 1'b1;
          state_d      = S_IDLE;
          if (lim_hit) begin
            err_d      = ST_OUT_LIMIT;
            push_o.res = '{out_byte: 8'h00, status: ST_OUT_LIMIT, run_last: 1'b1};
          end else begin
            hist_req_o.we    = 1'b1;
            hist_req_o.wdata = sbyte_q;
            wp_d    = wp_q + HIST_AW'(1);
            rec_d   = rec_inc;
            total_d = total_q + LIMIT_W'(1);
            push_o.res = '{out_byte: sbyte_q, status: ST_OK, run_last: 1'b1};
          end
          if (last_q && (err_d == ST_OK)) begin
            rec_d  = '0;
            lit_d  = '0;
            pend_d = 1'b0;
          end
        end
      end

      S_ERR1: begin
        if (room) begin
          push_o.valid = 1'b1;
          push_o.res   = '{out_byte: 8'h00, status: ST_LIT_OVERRUN, run_last: 1'b1};
          state_d      = S_IDLE;
        end
      end

      S_COPY: begin
        // Issue one history read per cycle while the result queue has room
        if (fill_ahead < (OFIFO_CW + 1)'(OFIFO_DEPTH)) begin
          s2_vld_d = 1'b1;
          if (lim_hit) begin
            err_d    = ST_OUT_LIMIT;
            s2_err_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            s2_err_d   = 1'b0;
            s2_waddr_d = wp_q;
            s2_last_d  = (cnt_q == 4'd1);
            wp_d    = wp_q + HIST_AW'(1);
            rec_d   = rec_inc;
            total_d = total_q + LIMIT_W'(1);
            src_d   = src_q + HIST_AW'(1);
            cnt_d   = cnt_q - 4'd1;
            if (cnt_q == 4'd1) begin
              state_d = S_IDLE;
            end
          end
          if ((state_d == S_IDLE) && last_q && (err_d == ST_OK)) begin
            rec_d  = '0;
            lit_d  = '0;
            pend_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      rec_q    <= '0;
      total_q  <= '0;
      limit_q  <= LIMIT_RESET;
      lit_q    <= '0;
      pend_q   <= 1'b0;
      phigh_q  <= '0;
      err_q    <= ST_OK;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      rec_q    <= rec_d;
      total_q  <= total_d;
      lit_q    <= lit_d;
      pend_q   <= pend_d;
      phigh_q  <= phigh_d;
      err_q    <= err_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      s2_vld_q <= s2_vld_d;
      if (cfg_wr_en_i) begin
        limit_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    sbyte_q    <= sbyte_d;
    s2_err_q   <= s2_err_d;
    s2_last_q  <= s2_last_d;
    s2_waddr_q <= s2_waddr_d;
  end

endmodule

### rtl/palmdoc_lz77_decompressor.sv
// Plain and literal bytes: one request per cycle, result in the cycle after acceptance.
// 0xC0..0xFF: a space, then the byte XOR 0x80; a literal that overruns its record: an
// extra error result. A copy pair: 3..10 history reads, one per cycle while the queue has
// room. A 4-entry result queue decouples the output; input stalls while it is full or a
// pair, space or error step runs. Reset clears all control state and errors, output_limit
// returns to 20971520; the history memory is not cleared, only the current record is read.
module palmdoc_lz77_decompressor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [pldz_pkg::LIMIT_W-1:0]  cfg_wr_data_i,   // output_limit
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // in_byte[7:0]
  input  logic                          s_axis_tlast_i,  // record_last
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,  // out_byte[7:0]
  output logic [2:0]                    m_axis_tuser_o,  // status[2:0]
  output logic                          m_axis_tlast_o   // run_last
);
  import pldz_pkg::*;

  push_t               push;
  hist_req_t           hist_req;
  logic [7:0]          hist_rdata;
  logic [OFIFO_CW-1:0] fifo_count;

  pldz_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_byte_i     (s_axis_tdata_i),
    .record_last_i (s_axis_tlast_i),
    .fifo_count_i  (fifo_count),
    .push_o        (push),
    .hist_req_o    (hist_req),
    .hist_rdata_i  (hist_rdata)
  );

  pldz_hist_ram #(
    .Depth (HIST_DEPTH),
    .Width (8)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_req.we),
    .waddr_i (hist_req.waddr),
    .wdata_i (hist_req.wdata),
    .raddr_i (hist_req.raddr),
    .rdata_o (hist_rdata)
  );

  pldz_out_fifo u_out_fifo (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .count_o         (fifo_count),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
